// ===== rtl/core/u16u8_pkg.sv =====
package u16u8_pkg;

  localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
  localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;
  localparam logic [15:0] SURR_END       = 16'hE000;
  localparam logic [20:0] SUPP_BASE      = 21'h10000;
  localparam logic [15:0] LIMIT_RESET    = 16'd512;

  localparam logic [7:0] CONT_MARK  = 8'h80;
  localparam logic [7:0] LEAD2_MARK = 8'hC0;
  localparam logic [7:0] LEAD3_MARK = 8'hE0;
  localparam logic [7:0] LEAD4_MARK = 8'hF0;
  localparam logic [7:0] CONT_MASK  = 8'h3F;

  localparam int MAX_BYTES = 6;

  // Surrogate and end state carried between units (count travels apart).
  typedef struct packed {
    logic [9:0] held_high;
    logic       held_valid;
    logic       text_done;
  } conv_state_t;

  // One unit's worth of results, ready for the output serializer.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                nbytes;
    logic                      ended;
  } burst_t;

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      len;
  } enc_t;

  function automatic enc_t utf8_encode(input logic [20:0] c);
    enc_t e;
    e.b   = '0;
    e.len = 3'd0;
    if (c < 21'h80) begin
      e.b[0] = c[7:0];
      e.len  = 3'd1;
    end else if (c < 21'h800) begin
      e.b[0] = LEAD2_MARK | {3'b000, c[10:6]};
      e.b[1] = CONT_MARK | ({2'b00, c[5:0]} & CONT_MASK);
      e.len  = 3'd2;
    end else if (c < 21'h10000) begin
      e.b[0] = LEAD3_MARK | {4'b0000, c[15:12]};
      e.b[1] = CONT_MARK | ({2'b00, c[11:6]} & CONT_MASK);
      e.b[2] = CONT_MARK | ({2'b00, c[5:0]} & CONT_MASK);
      e.len  = 3'd3;
    end else begin
      e.b[0] = LEAD4_MARK | {5'b00000, c[20:18]};
      e.b[1] = CONT_MARK | ({2'b00, c[17:12]} & CONT_MASK);
      e.b[2] = CONT_MARK | ({2'b00, c[11:6]} & CONT_MASK);
      e.b[3] = CONT_MARK | ({2'b00, c[5:0]} & CONT_MASK);
      e.len  = 3'd4;
    end
    return e;
  endfunction

endpackage

// ===== rtl/core/u16u8_step.sv =====
module u16u8_step #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic [15:0]              code_unit,
  input  logic                     text_start,
  input  u16u8_pkg::conv_state_t   state,
  input  logic [COUNT_WIDTH-1:0]   units_taken,
  input  logic [COUNT_WIDTH-1:0]   limit,
  output u16u8_pkg::conv_state_t   state_next,
  output logic [COUNT_WIDTH-1:0]   units_taken_next,
  output u16u8_pkg::burst_t        burst,
  output logic                     load
);

  u16u8_pkg::conv_state_t cur;
  logic [COUNT_WIDTH-1:0] cnt;
  logic [COUNT_WIDTH:0]   cnt_inc;
  logic                   at_limit;
  logic                   inc_at_limit;
  logic                   active;
  logic                   normal;
  logic                   is_high;
  logic                   is_low;
  logic                   ended;
  logic [2:0]             pre_len;
  u16u8_pkg::enc_t        pre_enc;
  u16u8_pkg::enc_t        main_enc;
  logic [2:0]             main_len;
  logic [2:0]             rel;

  always_comb begin
    cur          = text_start ? '0 : state;
    cnt          = text_start ? '0 : units_taken;
    active       = !cur.text_done;
    cnt_inc      = {1'b0, cnt} + {{COUNT_WIDTH{1'b0}}, 1'b1};
    at_limit     = (cnt >= limit);
    inc_at_limit = (cnt_inc >= {1'b0, limit});
    is_high      = (code_unit >= u16u8_pkg::HIGH_SURR_BASE) &&
                   (code_unit < u16u8_pkg::LOW_SURR_BASE);
    is_low       = (code_unit >= u16u8_pkg::LOW_SURR_BASE) &&
                   (code_unit < u16u8_pkg::SURR_END);
    pre_enc      = u16u8_pkg::utf8_encode({5'b0, u16u8_pkg::HIGH_SURR_BASE[15:10],
                                           cur.held_high});
    main_enc     = u16u8_pkg::utf8_encode({5'b0, code_unit});
    pre_len      = 3'd0;
    main_len     = 3'd0;
    ended        = 1'b0;
    normal       = 1'b1;
    state_next   = cur;
    units_taken_next = cnt;

    if (cur.held_valid) begin
      state_next.held_valid = 1'b0;
      state_next.held_high  = '0;
      if (at_limit) begin
        // Limit already reached: flush the held surrogate alone and end.
        pre_len = 3'd3;
        ended   = 1'b1;
        normal  = 1'b0;
      end else if (is_low) begin
        main_enc = u16u8_pkg::utf8_encode(u16u8_pkg::SUPP_BASE +
                                          {1'b0, cur.held_high, code_unit[9:0]});
        main_len = main_enc.len;
        units_taken_next = cnt_inc[COUNT_WIDTH-1:0];
        ended    = inc_at_limit;
        normal   = 1'b0;
      end else begin
        pre_len = 3'd3;
      end
    end

    if (normal) begin
      if (at_limit || code_unit == 16'd0) begin
        ended = 1'b1;
      end else if (is_high && !inc_at_limit) begin
        state_next.held_high  = code_unit[9:0];
        state_next.held_valid = 1'b1;
        units_taken_next      = cnt_inc[COUNT_WIDTH-1:0];
      end else begin
        main_len         = main_enc.len;
        units_taken_next = cnt_inc[COUNT_WIDTH-1:0];
        ended            = inc_at_limit;
      end
    end

    state_next.text_done = ended;

    for (int k = 0; k < u16u8_pkg::MAX_BYTES; k++) begin
      rel = 3'(k) - pre_len;
      burst.bytes[k] = (3'(k) < pre_len) ? pre_enc.b[k % 4] : main_enc.b[rel[1:0]];
    end
    burst.nbytes = pre_len + main_len;
    burst.ended  = ended;
    load         = active && (burst.nbytes != 3'd0 || ended);

    // Ignore the unit entirely once the text has ended.
    if (!active) begin
      state_next       = cur;
      units_taken_next = cnt;
    end
  end

endmodule

// ===== rtl/core/u16u8_burst.sv =====
module u16u8_burst (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  u16u8_pkg::burst_t burst,
  output logic              result_valid,
  input  logic              result_ready,
  output logic              free,
  output logic [7:0]        out_byte,
  output logic              byte_valid,
  output logic              run_last,
  output logic              text_end
);

  logic [u16u8_pkg::MAX_BYTES-1:0][7:0] bytes;
  logic [2:0] nbytes;
  logic       ended;
  logic       busy;
  logic [2:0] idx;
  logic [2:0] last;
  logic       marker;

  assign marker       = (nbytes == 3'd0);
  assign last         = marker ? 3'd0 : nbytes - 3'd1;
  assign result_valid = busy;
  assign run_last     = (idx == last);
  assign text_end     = ended && run_last;
  assign byte_valid   = !marker;
  assign out_byte     = marker ? 8'd0 : bytes[idx];
  assign free         = !busy || (result_ready && run_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 3'd0;
    end else if (load && free) begin
      busy <= 1'b1;
      idx  <= 3'd0;
    end else if (busy && result_ready) begin
      if (run_last) begin
        busy <= 1'b0;
        idx  <= 3'd0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      bytes  <= burst.bytes;
      nbytes <= burst.nbytes;
      ended  <= burst.ended;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx <= last)
    else $error("burst index past last byte");

  a_stall_holds_idx: assert property (@(posedge clk) disable iff (rst)
    busy && !result_ready |=> busy && $stable(idx))
    else $error("burst advanced while stalled");

  a_marker_single: assert property (@(posedge clk) disable iff (rst)
    busy && marker |-> idx == 3'd0 && ended)
    else $error("end marker not a single ending result");

endmodule

// ===== rtl/core/utf16_to_utf8_stream.sv =====
// Channel   Handshake                   Payload
// code      code_valid / code_ready     code_unit[15:0], text_start
// result    result_valid / result_ready out_byte[7:0], byte_valid, run_last, text_end
// limit     limit_we (no wait)          limit_wdata[15:0]
//
// A unit passes through the input register, then its results leave the output
// serializer one per cycle while result_ready is high: 1 to 6 results per unit.
// A unit that only holds a high surrogate, or comes after the end, yields no results.
// The next unit is taken while the last result of the current one is delivered.
// Synchronous reset clears the held surrogate, count, end flag and sets limit 512.
// A stall on result_ready holds the serializer, then the input register.
module utf16_to_utf8_stream #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        limit_we,
  input  logic [15:0] limit_wdata,
  input  logic        code_valid,
  output logic        code_ready,
  input  logic [15:0] code_unit,
  input  logic        text_start,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        run_last,
  output logic        text_end
);

  localparam int LW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  logic [15:0]            unit_limit;
  logic [COUNT_WIDTH-1:0] limit;
  logic [LW-1:0]          limit_wide;
  logic [LW-1:0]          cap_wide;

  // Input register
  logic        s1_valid;
  logic [15:0] s1_unit;
  logic        s1_start;
  logic        s1_adv;

  // Conversion state
  u16u8_pkg::conv_state_t state;
  u16u8_pkg::conv_state_t state_next;
  logic [COUNT_WIDTH-1:0] units_taken;
  logic [COUNT_WIDTH-1:0] units_taken_next;

  u16u8_pkg::burst_t burst;
  logic              load;
  logic              free;

  // Clamp the limit to what the counter can reach.
  assign limit_wide = LW'(unit_limit);
  assign cap_wide   = LW'({COUNT_WIDTH{1'b1}});
  assign limit      = (limit_wide > cap_wide) ? cap_wide[COUNT_WIDTH-1:0]
                                              : limit_wide[COUNT_WIDTH-1:0];

  // Advance the input register once the serializer can take its results.
  assign s1_adv     = s1_valid && free;
  assign code_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_limit <= u16u8_pkg::LIMIT_RESET;
    end else if (limit_we) begin
      unit_limit <= limit_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (code_ready) begin
      s1_valid <= code_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (code_ready && code_valid) begin
      s1_unit  <= code_unit;
      s1_start <= text_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= '0;
      units_taken <= '0;
    end else if (s1_adv) begin
      state       <= state_next;
      units_taken <= units_taken_next;
    end
  end

  u16u8_step #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .code_unit        (s1_unit),
    .text_start       (s1_start),
    .state            (state),
    .units_taken      (units_taken),
    .limit            (limit),
    .state_next       (state_next),
    .units_taken_next (units_taken_next),
    .burst            (burst),
    .load             (load)
  );

  // Drop a load that carries nothing; a holding unit simply retires.
  u16u8_burst u_burst (
    .clk          (clk),
    .rst          (rst),
    .load         (load && s1_adv),
    .burst        (burst),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .free         (free),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .run_last     (run_last),
    .text_end     (text_end)
  );

  a_done_not_held: assert property (@(posedge clk) disable iff (rst)
    state.text_done |-> !state.held_valid)
    else $error("surrogate held after text ended");

endmodule

// ===== dv/tb_utf16_to_utf8_stream.sv =====
`timescale 1ns / 100ps

module tb_utf16_to_utf8_stream;

  // Counter width of the instance (the block's default).
  localparam int COUNT_WIDTH = 16;
  // Generous ceiling on the whole run, in ns.
  localparam int RUN_LIMIT_NS = 5_000_000;
  // Cycles to let the input register empty before touching the limit.
  localparam int SETTLE_CYCLES = 10;
  localparam logic [15:0] LIMIT_MAX = 16'hFFFF;

  // One UTF-8 output transaction as the block presents it.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       text_end;
  } utf8_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        limit_we;
  logic [15:0] limit_wdata;
  logic        code_valid;
  logic        code_ready;
  logic [15:0] code_unit;
  logic        text_start;
  logic        result_valid;
  logic        result_ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        run_last;
  logic        text_end;

  utf16_to_utf8_stream #(.COUNT_WIDTH(COUNT_WIDTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .limit_we     (limit_we),
    .limit_wdata  (limit_wdata),
    .code_valid   (code_valid),
    .code_ready   (code_ready),
    .code_unit    (code_unit),
    .text_start   (text_start),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .run_last     (run_last),
    .text_end     (text_end)
  );

  always #5 clk = ~clk;

  // Expected UTF-8 transactions, oldest first.
  utf8_result_t pending_bytes[$];

  // Shadow of the converter: limit register plus per-text state.
  logic [15:0] limit_shadow;
  logic [9:0]  held_high_shadow;
  logic        held_valid_shadow;
  int unsigned units_shadow;
  logic        done_shadow;

  // Bytes produced by the unit being predicted.
  logic [7:0]  unit_bytes[u16u8_pkg::MAX_BYTES];
  int          unit_byte_count;

  int  mismatches = 0;
  int  units_converted = 0;
  int  texts_started = 0;
  int  results_checked = 0;
  bit  steady_flow = 1'b0;
  int  sink_hold_cycles = 0;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Append one expected transaction behind the others.
  function automatic void queue_expected(input utf8_result_t r);
    pending_bytes = {pending_bytes, r};
  endfunction

  // Append the UTF-8 form of one code point to this unit's byte list.
  function automatic void emit_code_point(input int unsigned cp);
    int n;
    int unsigned lead;
    if (cp < 'h80) begin
      unit_bytes[unit_byte_count] = cp[7:0];
      unit_byte_count++;
      return;
    end
    n    = (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
    lead = (n == 2) ? 'hC0 : (n == 3) ? 'hE0 : 'hF0;
    unit_bytes[unit_byte_count] = 8'(lead | (cp >> (6 * (n - 1))));
    unit_byte_count++;
    for (int k = n - 2; k >= 0; k--) begin
      unit_bytes[unit_byte_count] = 8'('h80 | ((cp >> (6 * k)) & 'h3F));
      unit_byte_count++;
    end
  endfunction

  // Advance the shadow by one accepted unit and queue the transactions it causes.
  // Returns 0 when the unit is dropped because the text has already ended.
  function automatic bit convert_unit(input logic [15:0] u, input logic start);
    int unsigned  lim;
    int unsigned  cap;
    bit           ended;
    bit           finished;
    bit           is_high;
    bit           is_low;
    utf8_result_t r;
    if (start) begin
      held_high_shadow  = '0;
      held_valid_shadow = 1'b0;
      units_shadow      = 0;
      done_shadow       = 1'b0;
      texts_started++;
    end else if (done_shadow) begin
      return 1'b0;
    end
    cap = (32'd1 << COUNT_WIDTH) - 1;
    lim = (32'(limit_shadow) > cap) ? cap : 32'(limit_shadow);
    is_high = (u >= u16u8_pkg::HIGH_SURR_BASE) && (u < u16u8_pkg::LOW_SURR_BASE);
    is_low  = (u >= u16u8_pkg::LOW_SURR_BASE) && (u < u16u8_pkg::SURR_END);
    unit_byte_count = 0;
    ended    = 1'b0;
    finished = 1'b0;

    if (held_valid_shadow) begin
      if (units_shadow >= lim) begin
        // No room left: flush the held surrogate alone and end the text.
        emit_code_point(32'(u16u8_pkg::HIGH_SURR_BASE | {6'b0, held_high_shadow}));
        ended    = 1'b1;
        finished = 1'b1;
      end else if (is_low) begin
        emit_code_point(32'(u16u8_pkg::SUPP_BASE) + (32'(held_high_shadow) << 10) +
                        (32'(u) - 32'(u16u8_pkg::LOW_SURR_BASE)));
        units_shadow++;
        ended    = (units_shadow >= lim);
        finished = 1'b1;
      end else begin
        emit_code_point(32'(u16u8_pkg::HIGH_SURR_BASE | {6'b0, held_high_shadow}));
      end
      held_valid_shadow = 1'b0;
      held_high_shadow  = '0;
    end

    if (!finished) begin
      if (units_shadow >= lim || u == 16'h0000) begin
        ended = 1'b1;
      end else if (is_high && units_shadow + 1 < lim) begin
        held_high_shadow  = u[9:0];
        held_valid_shadow = 1'b1;
        units_shadow++;
      end else begin
        emit_code_point(32'(u));
        units_shadow++;
        ended = (units_shadow >= lim);
      end
    end

    if (ended) done_shadow = 1'b1;
    for (int k = 0; k < unit_byte_count; k++) begin
      r.out_byte   = unit_bytes[k];
      r.byte_valid = 1'b1;
      r.run_last   = (k == unit_byte_count - 1);
      r.text_end   = ended && (k == unit_byte_count - 1);
      queue_expected(r);
    end
    if (ended && unit_byte_count == 0) begin
      // End with nothing to carry it: a bare end marker.
      r.out_byte   = 8'h00;
      r.byte_valid = 1'b0;
      r.run_last   = 1'b1;
      r.text_end   = 1'b1;
      queue_expected(r);
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Traffic helpers
  // ---------------------------------------------------------------------------

  // Idle length for either side: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one unit and hold it until the block takes it, then predict.
  // Entered and left at a rising edge.
  task automatic send_unit(input logic [15:0] u, input logic start);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      code_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    code_valid <= 1'b1;
    code_unit  <= u;
    text_start <= start;
    // Sample ready mid-cycle, where nothing is in motion.
    do @(negedge clk); while (code_ready !== 1'b1);
    @(posedge clk);
    if (convert_unit(u, start)) units_converted++;
  endtask

  // Drop valid and wait until every expected transaction has come back.
  task automatic drain_results(input int settle);
    code_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Write the unit limit only once the block has gone quiet.
  task automatic write_unit_limit(input logic [15:0] value);
    drain_results(SETTLE_CYCLES);
    limit_we    <= 1'b1;
    limit_wdata <= value;
    @(posedge clk);
    limit_we     <= 1'b0;
    limit_shadow  = value;
  endtask

  // Send one text of random characters: mostly well-formed UTF-16,
  // with lone surrogates, stray terminators and raw noise mixed in.
  task automatic send_random_text(input int n_chars);
    logic        first;
    int          r;
    logic [15:0] u;
    first = 1'b1;
    for (int i = 0; i < n_chars; i++) begin
      r = $urandom_range(0, 99);
      if (r < 22) begin
        u = 16'($urandom_range(1, 'h7F));
      end else if (r < 42) begin
        u = 16'($urandom_range('h80, 'h7FF));
      end else if (r < 62) begin
        u = $urandom_range(0, 1) ? 16'($urandom_range('h800, 'hD7FF))
                                 : 16'($urandom_range('hE000, 'hFFFF));
      end else if (r < 84) begin
        // Well-formed pair: send the high half here, the low half below.
        send_unit(u16u8_pkg::HIGH_SURR_BASE | 16'($urandom_range(0, 'h3FF)), first);
        first = 1'b0;
        u = u16u8_pkg::LOW_SURR_BASE | 16'($urandom_range(0, 'h3FF));
      end else if (r < 89) begin
        u = u16u8_pkg::HIGH_SURR_BASE | 16'($urandom_range(0, 'h3FF));
      end else if (r < 93) begin
        u = u16u8_pkg::LOW_SURR_BASE | 16'($urandom_range(0, 'h3FF));
      end else if (r < 98) begin
        u = 16'($urandom_range(0, 'hFFFF));
      end else begin
        u = 16'h0000;
      end
      send_unit(u, first);
      first = 1'b0;
    end
    // Terminate about half of the texts explicitly.
    if ($urandom_range(0, 1)) send_unit(16'h0000, first);
  endtask

  // Keep sending random texts until this many more units were converted.
  task automatic run_random_units(input int n_units);
    int goal;
    goal = units_converted + n_units;
    while (units_converted < goal) send_random_text($urandom_range(1, 24));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every encoding length, pairs, lone halves and the terminator at reset limit.
  task automatic test_directed_encoding();
    send_unit(16'h0041, 1'b1);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hFFFF, 1'b0);
    // Lowest and highest supplementary code points.
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFF, 1'b0);
    // High surrogate not followed by a low one, then the unit after it.
    send_unit(16'hD83D, 1'b0);
    send_unit(16'h0042, 1'b0);
    // Lone low surrogate.
    send_unit(16'hDC00, 1'b0);
    // High after high: the first goes out alone, the second pairs up.
    send_unit(16'hD800, 1'b0);
    send_unit(16'hD801, 1'b0);
    send_unit(16'hDC01, 1'b0);
    // Terminator with no bytes: end marker, then a dropped unit.
    send_unit(16'h0000, 1'b0);
    send_unit(16'h0041, 1'b0);
    // Text that is empty from its first unit.
    send_unit(16'h0000, 1'b1);
  endtask

  // Limit of zero, limit of one, and a limit lowered to the count
  // while a high surrogate is held.
  task automatic test_unit_limit_edges();
    write_unit_limit(16'd0);
    send_unit(16'h0061, 1'b1);
    send_unit(16'h0062, 1'b0);
    write_unit_limit(16'd1);
    send_unit(16'hD800, 1'b1);
    write_unit_limit(16'd3);
    send_unit(16'h0061, 1'b1);
    send_unit(16'hD800, 1'b0);
    write_unit_limit(16'd2);
    send_unit(16'h0063, 1'b0);
  endtask

  // Random texts across a sweep of limits, extremes included.
  task automatic test_random_texts();
    logic [15:0] limits[7];
    limits[0] = u16u8_pkg::LIMIT_RESET;
    limits[1] = LIMIT_MAX;
    limits[2] = 16'd1;
    limits[3] = 16'd2;
    limits[4] = 16'd3;
    limits[5] = 16'($urandom_range(4, 12));
    limits[6] = 16'($urandom_range(13, 80));
    foreach (limits[i]) begin
      write_unit_limit(limits[i]);
      // Run the widest limit without any idling on either side.
      steady_flow = (limits[i] == LIMIT_MAX);
      run_random_units(40);
      steady_flow = 1'b0;
    end
  endtask

  // Hold off the receiver for a long stretch while the sender keeps offering,
  // so the block fills and stalls its input.
  task automatic test_output_backpressure();
    write_unit_limit(u16u8_pkg::LIMIT_RESET);
    sink_hold_cycles = 300;
    run_random_units(60);
  endtask

  // Pause the sender until all results are back, several times over.
  task automatic test_sender_pause();
    write_unit_limit(16'($urandom_range(6, 40)));
    for (int i = 0; i < 6; i++) begin
      send_random_text($urandom_range(2, 10));
      drain_results($urandom_range(1, 6));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready, plus a long counted hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    result_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_cycles > 0) begin
        stall            = sink_hold_cycles;
        sink_hold_cycles = 0;
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else begin
        stall = pick_gap();
        result_ready <= (stall == 0);
        repeat (stall) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: compare each output transaction with the oldest expectation.
  // Sample mid-cycle; the transaction completes at the next rising edge.
  // ---------------------------------------------------------------------------
  utf8_result_t want;

  function automatic void check_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(negedge clk) begin
    if (rst === 1'b0 && result_valid === 1'b1 && result_ready === 1'b1) begin
      results_checked++;
      if (pending_bytes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transaction, expected none, actual byte %02h valid %b",
                 $time, out_byte, byte_valid);
      end else begin
        want = pending_bytes.pop_front();
        check_field("out_byte", want.out_byte, out_byte);
        check_field("byte_valid", 8'(want.byte_valid), 8'(byte_valid));
        check_field("run_last", 8'(want.run_last), 8'(run_last));
        check_field("text_end", 8'(want.text_end), 8'(text_end));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  initial begin
    #(RUN_LIMIT_NS);
    $display("%0t: timeout with %0d transactions outstanding", $time, pending_bytes.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst         = 1'b1;
    limit_we    = 1'b0;
    limit_wdata = '0;
    code_valid  = 1'b0;
    code_unit   = '0;
    text_start  = 1'b0;

    limit_shadow      = u16u8_pkg::LIMIT_RESET;
    held_high_shadow  = '0;
    held_valid_shadow = 1'b0;
    units_shadow      = 0;
    done_shadow       = 1'b0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_encoding();
    test_unit_limit_edges();
    test_random_texts();
    test_output_backpressure();
    test_sender_pause();

    // Let the tail drain, then allow a few more cycles for strays.
    drain_results(20);

    $display("Converted %0d UTF-16 units in %0d texts, %0d output transactions checked.",
             units_converted, texts_started, results_checked);
    $display("Limits swept from 0 to 65535 under random idling, output hold-off and pauses.");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
